// ----- sv/rlsb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsb_pkg
// Types and constants shared by the rainbow pixel sequencer and its checker.
// ----------------------------------------------------------------------------
package rlsb_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_OFF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEATS    = 3'd5;

    localparam logic [6:0]  RST_SATURATION = 7'd100;
    localparam logic [6:0]  RST_BRIGHTNESS = 7'd20;
    localparam logic [15:0] RST_FRAME      = 16'd20;
    localparam logic [15:0] RST_FLASH_ON   = 16'd50;
    localparam logic [15:0] RST_FLASH_OFF  = 16'd50;
    localparam logic [3:0]  RST_REPEATS    = 4'd3;

    localparam logic [6:0] PCT_MAX     = 7'd100;
    localparam logic [7:0] LEVEL_MAX   = 8'd255;
    localparam logic [2:0] LAST_SECTOR = 3'd5;
    localparam logic [5:0] LAST_DEG    = 6'd59;

    // floor(x/100) = (x*5243)>>19 for x < 25600
    // floor(x/60)  = (x*17477)>>20 for x < 15360
    localparam logic [14:0] RECIP_100    = 15'd5243;
    localparam int          RECIP_100_SH = 19;
    localparam logic [14:0] RECIP_60     = 15'd17477;
    localparam int          RECIP_60_SH  = 20;

    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 15;

    typedef enum logic [1:0] {
        PH_RAINBOW = 2'd0,
        PH_LIT     = 2'd1,
        PH_DARK    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

    // multiply steps of the HSV conversion
    typedef enum logic [2:0] {
        MS_V255    = 3'd0,
        MS_DIV_MX  = 3'd1,
        MS_SAT     = 3'd2,
        MS_DIV_MN  = 3'd3,
        MS_SPAN    = 3'd4,
        MS_DIV_ADJ = 3'd5
    } t_mstep;

endpackage
`default_nettype wire

// ----- sv/rlsb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsb_tick_if / rlsb_pix_if
// Valid/ready channels: tick requests in, pixel results out.
// ----------------------------------------------------------------------------
interface rlsb_tick_if;
    logic valid;
    logic ready;
    logic trigger;

    modport source (output valid, output trigger, input ready);
    modport sink   (input valid, input trigger, output ready);
endinterface

interface rlsb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       refresh;
    logic       flashing;

    modport source (output valid, output red, output green, output blue,
                    output refresh, output flashing, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input refresh, input flashing, output ready);
endinterface
`default_nettype wire

// ----- sv/rainbow_led_sequencer_with_blink_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rainbow_led_sequencer_with_blink_unit
// One RGB pixel: rainbow hue cycle with blue flash runs on blink requests.
// ----------------------------------------------------------------------------
// One request on i_tick is one time-base tick; it yields exactly one pixel
// request on o_pix. A tick that only counts down a segment, or that starts a
// flash or a dark gap, is accepted and then loads the output register. A tick
// that shows a new rainbow color first runs six multiplications through one
// bit-serial shift-add multiplier, one multiplier bit per cycle, and then
// loads the output register. Ticks are taken one at a time, and the next tick
// is accepted while the previous result still waits in the output register.
// Configuration writes are taken at any edge with i_cfg_we high and are meant
// for idle periods only.
// ----------------------------------------------------------------------------
module rainbow_led_sequencer_with_blink_unit #(
    parameter int TIMER_BITS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [rlsb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [rlsb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rlsb_tick_if.sink                       i_tick,
    rlsb_pix_if.source                      o_pix
);
    import rlsb_pkg::*;

    // configuration
    logic [6:0]  r_sat, r_bri;
    logic [15:0] r_frame, r_on, r_off;
    logic [3:0]  r_rep;

    // sequencer state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [3:0]          r_left, n_left;
    logic                r_pend, n_pend;
    logic [2:0]          r_hue_sec, n_hue_sec;
    logic [5:0]          r_hue_deg, n_hue_deg;
    logic [23:0]         r_pix, n_pix;
    logic                r_refresh, n_refresh;

    // HSV datapath
    t_mstep              r_step, n_step;
    logic [2:0]          r_sec, n_sec;
    logic [5:0]          r_deg, n_deg;
    logic [7:0]          r_mx, n_mx;
    logic [7:0]          r_mn, n_mn;
    logic [MUL_A_W-1:0]  r_mul_a, n_mul_a;
    logic [MUL_B_W-1:0]  r_mul_b, n_mul_b;
    logic [MUL_A_W-1:0]  r_acc, n_acc;

    // output register
    logic                r_out_valid;
    logic [23:0]         r_out_pix;
    logic                r_out_refresh;
    logic                r_out_flashing;

    logic w_accept, w_mul_done, w_out_load;
    logic [6:0] w_sat_c, w_bri_c;
    logic [7:0] w_adj;
    logic [7:0] w_div;

    function automatic logic [TIMER_BITS-1:0] seg_load(input logic [15:0] len);
        logic [15:0] m1;
        logic [31:0] w;
        logic [TIMER_BITS-1:0] res;
        m1 = (len == 16'd0) ? 16'd0 : len - 16'd1;
        w  = 32'(m1);
        if ((w >> TIMER_BITS) != 32'd0) begin
            res = '1;
        end else begin
            res = w[TIMER_BITS-1:0];
        end
        return res;
    endfunction

    assign w_sat_c = (r_sat > PCT_MAX) ? PCT_MAX : r_sat;
    assign w_bri_c = (r_bri > PCT_MAX) ? PCT_MAX : r_bri;
    assign w_div   = r_acc[RECIP_100_SH +: 8];
    assign w_adj   = r_acc[RECIP_60_SH +: 8];

    // control strobes
    always_comb begin
        w_accept   = i_tick.valid && (r_state == ST_IDLE);
        w_mul_done = (r_state == ST_MUL) && (r_mul_b == '0);
        w_out_load = (r_state == ST_OUT) && (!r_out_valid || o_pix.ready);
    end

    assign i_tick.ready   = (r_state == ST_IDLE);
    assign o_pix.valid    = r_out_valid;
    assign o_pix.red      = r_out_pix[23:16];
    assign o_pix.green    = r_out_pix[15:8];
    assign o_pix.blue     = r_out_pix[7:0];
    assign o_pix.refresh  = r_out_refresh;
    assign o_pix.flashing = r_out_flashing;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (n_step == MS_V255 && n_phase == PH_RAINBOW
                               && n_refresh) ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                if (w_mul_done && r_step == MS_DIV_ADJ) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer and datapath
    always_comb begin
        logic show_rainbow;
        logic pend;
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_left    = r_left;
        n_pend    = r_pend;
        n_hue_sec = r_hue_sec;
        n_hue_deg = r_hue_deg;
        n_pix     = r_pix;
        n_refresh = r_refresh;
        n_step    = r_step;
        n_sec     = r_sec;
        n_deg     = r_deg;
        n_mx      = r_mx;
        n_mn      = r_mn;
        n_acc     = r_acc;
        n_mul_a   = r_mul_a;
        n_mul_b   = r_mul_b;
        show_rainbow = 1'b0;
        pend = r_pend | i_tick.trigger;

        if (w_accept) begin
            n_pend    = pend;
            n_refresh = 1'b0;
            n_step    = MS_DIV_ADJ;
            if (r_timer != '0) begin
                n_timer = r_timer - TIMER_BITS'(1);
            end else begin
                n_refresh = 1'b1;
                case (r_phase)
                    PH_LIT: begin
                        n_pix   = 24'd0;
                        n_phase = PH_DARK;
                        n_timer = seg_load(r_off);
                    end
                    PH_DARK: begin
                        if (r_left != 4'd0) begin
                            n_left  = r_left - 4'd1;
                            n_pix   = {16'd0, LEVEL_MAX};
                            n_phase = PH_LIT;
                            n_timer = seg_load(r_on);
                        end else begin
                            show_rainbow = 1'b1;
                        end
                    end
                    default: begin
                        if (pend) begin
                            n_pend = 1'b0;
                            if (r_rep != 4'd0) begin
                                n_left  = r_rep - 4'd1;
                                n_pix   = {16'd0, LEVEL_MAX};
                                n_phase = PH_LIT;
                                n_timer = seg_load(r_on);
                            end else begin
                                show_rainbow = 1'b1;
                            end
                        end else begin
                            show_rainbow = 1'b1;
                        end
                    end
                endcase
            end
            if (show_rainbow) begin
                n_phase = PH_RAINBOW;
                n_timer = seg_load(r_frame);
                n_sec   = r_hue_sec;
                n_deg   = r_hue_deg;
                if (r_hue_deg == LAST_DEG) begin
                    n_hue_deg = 6'd0;
                    n_hue_sec = (r_hue_sec == LAST_SECTOR) ? 3'd0 : r_hue_sec + 3'd1;
                end else begin
                    n_hue_deg = r_hue_deg + 6'd1;
                end
                n_step  = MS_V255;
                n_acc   = '0;
                n_mul_a = MUL_A_W'(w_bri_c);
                n_mul_b = MUL_B_W'(LEVEL_MAX);
            end
        end else if (r_state == ST_MUL) begin
            if (!w_mul_done) begin
                // one multiplier bit per cycle, LSB first
                if (r_mul_b[0]) begin
                    n_acc = r_acc + r_mul_a;
                end
                n_mul_a = r_mul_a << 1;
                n_mul_b = r_mul_b >> 1;
            end else begin
                n_acc = '0;
                case (r_step)
                    MS_V255: begin
                        n_step  = MS_DIV_MX;
                        n_mul_a = MUL_A_W'(r_acc[14:0]);
                        n_mul_b = RECIP_100;
                    end
                    MS_DIV_MX: begin
                        n_mx    = w_div;
                        n_step  = MS_SAT;
                        n_mul_a = MUL_A_W'(w_div);
                        n_mul_b = MUL_B_W'(PCT_MAX - w_sat_c);
                    end
                    MS_SAT: begin
                        n_step  = MS_DIV_MN;
                        n_mul_a = MUL_A_W'(r_acc[14:0]);
                        n_mul_b = RECIP_100;
                    end
                    MS_DIV_MN: begin
                        n_mn    = w_div;
                        n_step  = MS_SPAN;
                        n_mul_a = MUL_A_W'(r_mx - w_div);
                        n_mul_b = MUL_B_W'(r_deg);
                    end
                    MS_SPAN: begin
                        n_step  = MS_DIV_ADJ;
                        n_mul_a = MUL_A_W'(r_acc[14:0]);
                        n_mul_b = RECIP_60;
                    end
                    default: begin
                        case (r_sec)
                            3'd0: n_pix = {r_mx, r_mn + w_adj, r_mn};
                            3'd1: n_pix = {r_mx - w_adj, r_mx, r_mn};
                            3'd2: n_pix = {r_mn, r_mx, r_mn + w_adj};
                            3'd3: n_pix = {r_mn, r_mx - w_adj, r_mx};
                            3'd4: n_pix = {r_mn + w_adj, r_mn, r_mx};
                            default: n_pix = {r_mx, r_mn, r_mx - w_adj};
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat   <= RST_SATURATION;
            r_bri   <= RST_BRIGHTNESS;
            r_frame <= RST_FRAME;
            r_on    <= RST_FLASH_ON;
            r_off   <= RST_FLASH_OFF;
            r_rep   <= RST_REPEATS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SATURATION: r_sat   <= i_cfg_data[6:0];
                CFG_BRIGHTNESS: r_bri   <= i_cfg_data[6:0];
                CFG_FRAME:      r_frame <= i_cfg_data;
                CFG_FLASH_ON:   r_on    <= i_cfg_data;
                CFG_FLASH_OFF:  r_off   <= i_cfg_data;
                CFG_REPEATS:    r_rep   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_RAINBOW;
            r_timer     <= '0;
            r_left      <= 4'd0;
            r_pend      <= 1'b0;
            r_hue_sec   <= 3'd0;
            r_hue_deg   <= 6'd0;
            r_pix       <= 24'd0;
            r_step      <= MS_V255;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_left    <= n_left;
            r_pend    <= n_pend;
            r_hue_sec <= n_hue_sec;
            r_hue_deg <= n_hue_deg;
            r_pix     <= n_pix;
            r_step    <= n_step;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_refresh <= n_refresh;
        r_sec     <= n_sec;
        r_deg     <= n_deg;
        r_mx      <= n_mx;
        r_mn      <= n_mn;
        r_acc     <= n_acc;
        r_mul_a   <= n_mul_a;
        r_mul_b   <= n_mul_b;
        if (w_out_load) begin
            r_out_pix      <= r_pix;
            r_out_refresh  <= r_refresh;
            r_out_flashing <= (r_phase == PH_LIT) || (r_phase == PH_DARK);
        end
    end

endmodule
`default_nettype wire

// ----- sv/rlsb_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlsb_chk
// Port-level checks for the rainbow pixel sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rlsb_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_red,
    input wire [7:0] i_green,
    input wire [7:0] i_blue,
    input wire       i_refresh,
    input wire       i_flashing
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output request valid after reset");

    // one tick in flight: ready drops right after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second tick accepted while one is in work");

    // during a flash run the pixel is full blue or dark
    a_flash_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_flashing |->
            (i_red == 8'd0 && i_green == 8'd0 && (i_blue == 8'd255 || i_blue == 8'd0)))
        else $error("flash run shows a non-blue color");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red)
            && $stable(i_green) && $stable(i_blue) && $stable(i_refresh)
            && $stable(i_flashing))
        else $error("stalled pixel request changed");

endmodule

bind rainbow_led_sequencer_with_blink_unit rlsb_chk u_rlsb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tick.valid),
    .i_in_ready  (i_tick.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red),
    .i_green     (o_pix.green),
    .i_blue      (o_pix.blue),
    .i_refresh   (o_pix.refresh),
    .i_flashing  (o_pix.flashing)
);
`default_nettype wire

// ----- tb/rainbow_led_sequencer_with_blink_unit_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rainbow_led_sequencer_with_blink_unit_chk
// Watches the tick and pixel channels and the register port. It keeps its own
// copy of the sequencer state, predicts the pixel request for every accepted
// tick and compares each returned pixel request against the oldest prediction.
// ----------------------------------------------------------------------------
module rainbow_led_sequencer_with_blink_unit_chk (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [rlsb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [rlsb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rlsb_tick_if                            i_tick,
    rlsb_pix_if                             i_pix,
    output int                              o_errors,
    output int                              o_pending
);
    import rlsb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       refresh;
        logic       flashing;
    } pixel_res_t;

    // register copies
    logic [6:0]  sat_pct;
    logic [6:0]  bri_pct;
    logic [15:0] frame_len;
    logic [15:0] lit_len;
    logic [15:0] dark_len;
    logic [3:0]  flash_count;

    // sequencer state
    logic [8:0]  hue;
    t_phase      seg_phase;
    logic [15:0] seg_timer;
    logic [3:0]  flashes_due;
    logic        blink_waiting;
    logic [23:0] rgb;

    pixel_res_t  expected_pixels[$];
    pixel_res_t  want;
    pixel_res_t  seen;
    int          fail_cnt = 0;

    // a segment of len ticks counts down from len-1; zero acts as one
    function automatic logic [15:0] seg_reload(input logic [15:0] len);
        return (len == 16'd0) ? 16'd0 : len - 16'd1;
    endfunction

    function automatic logic [23:0] hsv_rgb(input logic [8:0] h, input logic [6:0] s_pct,
                                            input logic [6:0] v_pct);
        int unsigned s;
        int unsigned v;
        int unsigned mx_lvl;
        int unsigned mn_lvl;
        int unsigned ramp;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  up;
        logic [7:0]  down;
        s = (s_pct > PCT_MAX) ? PCT_MAX : s_pct;
        v = (v_pct > PCT_MAX) ? PCT_MAX : v_pct;
        mx_lvl = v * LEVEL_MAX / PCT_MAX;
        mn_lvl = mx_lvl * (PCT_MAX - s) / PCT_MAX;
        ramp = (mx_lvl - mn_lvl) * (h % 60) / 60;
        hi   = mx_lvl[7:0];
        lo   = mn_lvl[7:0];
        up   = lo + ramp[7:0];
        down = hi - ramp[7:0];
        case (h / 60)
            0: return {hi, up, lo};
            1: return {down, hi, lo};
            2: return {lo, hi, up};
            3: return {lo, down, hi};
            4: return {up, lo, hi};
            default: return {hi, lo, down};
        endcase
    endfunction

    function automatic void show_hue();
        rgb       = hsv_rgb(hue, sat_pct, bri_pct);
        hue       = (hue == 9'd359) ? 9'd0 : hue + 9'd1;
        seg_phase = PH_RAINBOW;
        seg_timer = seg_reload(frame_len);
    endfunction

    function automatic void light_blue();
        rgb       = {8'd0, 8'd0, LEVEL_MAX};
        seg_phase = PH_LIT;
        seg_timer = seg_reload(lit_len);
    endfunction

    function automatic pixel_res_t predict_tick(input logic trig);
        logic strobe;
        strobe = 1'b0;
        if (trig)
            blink_waiting = 1'b1;
        if (seg_timer != 16'd0) begin
            seg_timer = seg_timer - 16'd1;
        end else begin
            strobe = 1'b1;
            case (seg_phase)
                PH_LIT: begin
                    rgb       = 24'd0;
                    seg_phase = PH_DARK;
                    seg_timer = seg_reload(dark_len);
                end
                PH_DARK: begin
                    if (flashes_due != 4'd0) begin
                        flashes_due = flashes_due - 4'd1;
                        light_blue();
                    end else begin
                        show_hue();
                    end
                end
                default: begin
                    // a request taken with zero repeats goes straight to the rainbow
                    if (blink_waiting && flash_count != 4'd0) begin
                        blink_waiting = 1'b0;
                        flashes_due   = flash_count - 4'd1;
                        light_blue();
                    end else begin
                        blink_waiting = 1'b0;
                        show_hue();
                    end
                end
            endcase
        end
        return {rgb, strobe, (seg_phase == PH_LIT) || (seg_phase == PH_DARK)};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sat_pct       = RST_SATURATION;
            bri_pct       = RST_BRIGHTNESS;
            frame_len     = RST_FRAME;
            lit_len       = RST_FLASH_ON;
            dark_len      = RST_FLASH_OFF;
            flash_count   = RST_REPEATS;
            hue           = 9'd0;
            seg_phase     = PH_RAINBOW;
            seg_timer     = 16'd0;
            flashes_due   = 4'd0;
            blink_waiting = 1'b0;
            rgb           = 24'd0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SATURATION: sat_pct     = i_cfg_data[6:0];
                    CFG_BRIGHTNESS: bri_pct     = i_cfg_data[6:0];
                    CFG_FRAME:      frame_len   = i_cfg_data;
                    CFG_FLASH_ON:   lit_len     = i_cfg_data;
                    CFG_FLASH_OFF:  dark_len    = i_cfg_data;
                    CFG_REPEATS:    flash_count = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_tick.valid && i_tick.ready)
                expected_pixels.push_back(predict_tick(i_tick.trigger));
            if (i_pix.valid && i_pix.ready) begin
                seen = {i_pix.red, i_pix.green, i_pix.blue, i_pix.refresh, i_pix.flashing};
                if (expected_pixels.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: pixel request with none expected: rgb=%h refresh=%b flashing=%b",
                                 $realtime, {seen.red, seen.green, seen.blue}, seen.refresh,
                                 seen.flashing);
                end else begin
                    want = expected_pixels.pop_front();
                    if (seen.red !== want.red || seen.green !== want.green ||
                        seen.blue !== want.blue || seen.refresh !== want.refresh ||
                        seen.flashing !== want.flashing) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d refresh=%b flashing=%b, got r=%0d g=%0d b=%0d refresh=%b flashing=%b",
                                     $realtime, want.red, want.green, want.blue, want.refresh,
                                     want.flashing, seen.red, seen.green, seen.blue, seen.refresh,
                                     seen.flashing);
                    end
                end
            end
        end
        o_errors  <= fail_cnt;
        o_pending <= expected_pixels.size();
    end

endmodule

// ----- tb/rainbow_led_sequencer_with_blink_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rainbow_led_sequencer_with_blink_unit_tb
// Drives ticks with and without blink requests through a series of register
// settings, with random gaps and stalls and one long output hold-off. The
// checker beside the block predicts and compares every pixel request.
// ----------------------------------------------------------------------------
module rainbow_led_sequencer_with_blink_unit_tb;
    import rlsb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE      = 80;
    localparam int unsigned HOLD_AFTER  = 400;
    localparam int unsigned HOLD_CYCLES = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    chk_errors;
    int                    chk_pending;

    bit                    gaps_on;
    int unsigned           n_ticks = 0;
    int unsigned           n_requests = 0;
    int unsigned           n_settings = 0;

    rlsb_tick_if tick_ch ();
    rlsb_pix_if  pix_ch ();

    always #5 i_clk = ~i_clk;

    rainbow_led_sequencer_with_blink_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_tick     (tick_ch),
        .o_pix      (pix_ch)
    );

    rainbow_led_sequencer_with_blink_unit_chk i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_tick     (tick_ch),
        .i_pix      (pix_ch),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // narrow registers get random junk above their width
    task automatic load_regs(input logic [6:0] sat, input logic [6:0] bri,
                             input logic [15:0] frame_len, input logic [15:0] lit_len,
                             input logic [15:0] dark_len, input logic [3:0] reps);
        logic [15:0] junk;
        junk = $urandom;
        cfg_write(CFG_SATURATION, {junk[15:7], sat});
        cfg_write(CFG_BRIGHTNESS, {junk[8:0], bri});
        cfg_write(CFG_FRAME, frame_len);
        cfg_write(CFG_FLASH_ON, lit_len);
        cfg_write(CFG_FLASH_OFF, dark_len);
        cfg_write(CFG_REPEATS, {junk[11:0], reps});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_tick(input logic trig);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.trigger <= trig;
        n_ticks++;
        if (trig)
            n_requests++;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    // bit k of the pattern is the trigger of tick k
    task automatic send_pattern(input logic [15:0] bits, input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_tick(bits[k]);
    endtask

    // every tick gives one pixel request, so an empty scoreboard means idle
    task automatic drain_all();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [6:0] pick_pct();
        case ($urandom_range(0, 3))
            0: return 7'd0;
            1: return PCT_MAX;
            2: return $urandom_range(101, 127);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    function automatic logic [15:0] pick_len();
        return ($urandom_range(0, 7) == 0) ? 16'd0 : $urandom_range(1, 4);
    endfunction

    task automatic random_phase(input int unsigned n, input bit gaps);
        logic [3:0]  reps;
        int unsigned odds;
        case ($urandom_range(0, 5))
            0: reps = 4'd0;
            1: reps = $urandom_range(4, 15);
            default: reps = $urandom_range(1, 3);
        endcase
        case ($urandom_range(0, 2))
            0: odds = 2;
            1: odds = 6;
            default: odds = 25;
        endcase
        gaps_on = gaps;
        load_regs(pick_pct(), pick_pct(), pick_len(), pick_len(), pick_len(), reps);
        repeat (n) send_tick($urandom_range(1, odds) == 1);
        drain_all();
    endtask

    // receiver: random stall bursts plus one long hold-off to back the block up
    initial begin : pixel_sink
        int unsigned taken;
        int unsigned hold_left;
        int unsigned stall_left;
        bit          held;
        taken      = 0;
        hold_left  = 0;
        stall_left = 0;
        held       = 1'b0;
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_ch.valid && pix_ch.ready)
                taken++;
            if (hold_left != 0) begin
                hold_left--;
            end else if (!held && taken >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                pix_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                pix_ch.ready <= 1'b0;
            end else begin
                pix_ch.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge i_clk);
        $display("timed out after %0d cycles", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned k;
        gaps_on = 1'b1;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_SATURATION;
        cfg_data        <= '0;
        tick_ch.valid   <= 1'b0;
        tick_ch.trigger <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-tick frames so reset saturation and brightness show at once
        cfg_write(CFG_FRAME, 16'd1);
        cfg_we <= 1'b0;
        send_pattern(16'b00, 2);
        drain_all();

        // levels above 100, zero lengths, request arriving during a run
        load_regs(7'd127, 7'd127, 16'd0, 16'd0, 16'd0, 4'd2);
        @(posedge i_clk);
        cfg_write(CFG_SPARE_LO, 16'hFFFF);
        cfg_write(CFG_SPARE_HI, 16'hFFFF);
        cfg_we <= 1'b0;
        send_pattern(16'b0000000101, 10);
        drain_all();

        // zero repeats: request is dropped and the rainbow goes on
        load_regs(7'd0, 7'd0, 16'd1, 16'd1, 16'd1, 4'd0);
        send_pattern(16'b101, 3);
        drain_all();

        load_regs(7'd50, PCT_MAX, 16'd2, 16'd1, 16'd2, 4'd15);
        send_pattern(16'b00000001, 8);
        drain_all();

        // reset timing: long frames, three flashes per run, random requests
        load_regs(RST_SATURATION, RST_BRIGHTNESS, RST_FRAME, RST_FLASH_ON, RST_FLASH_OFF,
                  RST_REPEATS);
        repeat (320) send_tick($urandom_range(1, 40) == 1);
        drain_all();

        // one hue per tick, enough to wrap the hue
        load_regs($urandom_range(0, 100), PCT_MAX, 16'd1, 16'd1, 16'd1, 4'd1);
        repeat (380) send_tick($urandom_range(1, 100) == 1);
        drain_all();

        for (k = 0; k < 8; k++)
            random_phase(110, (k < 6) ? ($urandom_range(0, 3) != 0) : 1'b0);

        // longest segments last: the timer would hold every later phase up
        gaps_on = 1'b0;
        load_regs(PCT_MAX, PCT_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_tick(1'b1);
        repeat (24) send_tick(1'b0);
        drain_all();

        $display("sent %0d ticks (%0d with a blink request) over %0d register settings",
                 n_ticks, n_requests, n_settings);
        $display("run included a full hue wrap, flash runs up to 15 long and a long output hold-off");
        if (chk_errors == 0 && chk_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
